FILE: hdl/ttcb_pkg.sv
package ttcb_pkg;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // byte codes
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI  = 8'h7F;

   // register indexes and reset values
   localparam logic       CSR_COLUMNS = 1'b0;
   localparam logic       CSR_ROWS    = 1'b1;
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd30;

   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
      logic [5:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [5:0] cursor_row;
      logic [7:0] cursor_col;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic read_cell;
      logic store_char;
      logic move_back;
      logic move_down;
      logic move_home_last;
      logic walk_en;
      logic walk_wipe;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic is_backspace;
      logic is_newline;
      logic is_printable;
      logic on_last_row;
      logic col_room;
      logic last_wipe;
      logic last_scroll;
      logic rsp_free;
   } status_type;

endpackage

FILE: hdl/ttcb_ctrl.sv
module ttcb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ttcb_pkg::status_type status,
   output ttcb_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.walk_en   = 1'b1;
            cmd.walk_wipe = 1'b1;
            if (status.last_wipe) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (status.is_read) begin
               cmd.read_cell = 1'b1;
            end else if (status.is_printable) begin
               cmd.store_char = status.col_room;
            end else if (status.is_backspace) begin
               cmd.move_back = 1'b1;
            end else if (status.is_newline) begin
               if (status.on_last_row) begin
                  cmd.move_home_last = 1'b1;
                  state_in           = ST_SCROLL;
               end else begin
                  cmd.move_down = 1'b1;
               end
            end
         end
         ST_SCROLL: begin
            cmd.walk_en = 1'b1;
            if (status.last_scroll) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: hdl/ttcb_datapath.sv
module ttcb_datapath #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ttcb_pkg::req_type    req_data,
   output ttcb_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [7:0]           csr_data,
   input  ttcb_pkg::cmd_type    cmd,
   output ttcb_pkg::status_type status
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int EROW_W = ROW_W + 1;
   localparam int ECOL_W = COL_W + 1;
   localparam int AW     = ROW_W + COL_W;
   localparam int DEPTH  = 1 << AW;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

   logic [7:0] cell_mem [0:DEPTH-1];
   logic [7:0] mem_q_ff;

   ttcb_pkg::req_type req_ff;
   ttcb_pkg::rsp_type rsp_ff;
   ttcb_pkg::rsp_type rsp_in;
   logic              rsp_valid_ff;

   logic [7:0]        cfg_cols_ff;
   logic [6:0]        cfg_rows_ff;
   logic [ECOL_W-1:0] eff_cols;
   logic [EROW_W-1:0] eff_rows;

   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [ECOL_W-1:0] cursor_col_ff, cursor_col_in;

   logic [EROW_W-1:0] walk_row_ff, walk_row_in;
   logic [COL_W-1:0]  walk_col_ff, walk_col_in;
   logic              wr_pend_ff;
   logic [AW-1:0]     wr_addr_ff;
   logic              wr_zero_ff;

   logic              col_last;
   logic              walk_last;
   logic              in_area;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     store_addr;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= ttcb_pkg::COLUMNS_RESET;
         cfg_rows_ff <= ttcb_pkg::ROWS_RESET;
      end else if (csr_valid) begin
         if (csr_index == ttcb_pkg::CSR_COLUMNS) cfg_cols_ff <= csr_data;
         if (csr_index == ttcb_pkg::CSR_ROWS) cfg_rows_ff <= csr_data[6:0];
      end
   end

   // saturate the screen size to what the store holds; a size of 0 counts as 1
   always_comb begin
      if (cfg_cols_ff == 8'd0) begin
         eff_cols = ECOL_W'(1);
      end else if ({1'b0, cfg_cols_ff} > 9'(MAX_COLS)) begin
         eff_cols = ECOL_W'(MAX_COLS);
      end else begin
         eff_cols = ECOL_W'(cfg_cols_ff);
      end
      if (cfg_rows_ff == 7'd0) begin
         eff_rows = EROW_W'(1);
      end else if ({1'b0, cfg_rows_ff} > 8'(MAX_ROWS)) begin
         eff_rows = EROW_W'(MAX_ROWS);
      end else begin
         eff_rows = EROW_W'(cfg_rows_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_data;
   end

   // decode
   always_comb begin
      status.is_read      = (req_ff.operation == ttcb_pkg::OP_READ);
      status.is_backspace = !status.is_read && (req_ff.char_code == ttcb_pkg::CHAR_BACKSPACE);
      status.is_newline   = !status.is_read && (req_ff.char_code == ttcb_pkg::CHAR_NEWLINE);
      status.is_printable = !status.is_read && (req_ff.char_code >= ttcb_pkg::CHAR_PRINT_LO)
                            && (req_ff.char_code <= ttcb_pkg::CHAR_PRINT_HI);
      status.on_last_row  = ({1'b0, cursor_row_ff} >= (eff_rows - EROW_W'(1)));
      status.col_room     = (cursor_col_ff < eff_cols);
      status.last_wipe    = col_last && (walk_row_ff == EROW_W'(MAX_ROWS));
      status.last_scroll  = col_last && (walk_row_ff == eff_rows);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // cursor
   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      if (cmd.store_char) begin
         cursor_col_in = cursor_col_ff + ECOL_W'(1);
      end else if (cmd.move_back) begin
         if (cursor_col_ff != '0) cursor_col_in = cursor_col_ff - ECOL_W'(1);
      end else if (cmd.move_down) begin
         cursor_row_in = cursor_row_ff + ROW_W'(1);
         cursor_col_in = '0;
      end else if (cmd.move_home_last) begin
         cursor_row_in = ROW_W'(eff_rows - EROW_W'(1));
         cursor_col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
      end else begin
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
      end
   end

   // row walker: reads source row r, writes row r-1 from the registered read;
   // the row past the last one in use is the zero fill
   assign col_last  = (walk_col_ff == COL_LAST);
   assign walk_last = cmd.walk_wipe ? status.last_wipe : status.last_scroll;

   always_comb begin
      walk_row_in = walk_row_ff;
      walk_col_in = walk_col_ff;
      if (cmd.walk_en) begin
         if (walk_last) begin
            walk_row_in = EROW_W'(1);
            walk_col_in = '0;
         end else if (col_last) begin
            walk_row_in = walk_row_ff + EROW_W'(1);
            walk_col_in = '0;
         end else begin
            walk_col_in = walk_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_row_ff <= EROW_W'(1);
         walk_col_ff <= '0;
         wr_pend_ff  <= 1'b0;
      end else begin
         walk_row_ff <= walk_row_in;
         walk_col_ff <= walk_col_in;
         wr_pend_ff  <= cmd.walk_en;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= {ROW_W'(walk_row_ff - EROW_W'(1)), walk_col_ff};
      wr_zero_ff <= cmd.walk_wipe || (walk_row_ff == eff_rows);
   end

   // cell store
   assign in_area    = ({3'b0, req_ff.read_row} < 9'(eff_rows))
                       && ({2'b0, req_ff.read_col} < 9'(eff_cols));
   assign store_addr = {cursor_row_ff, cursor_col_ff[COL_W-1:0]};
   assign rd_addr    = cmd.walk_en ? {walk_row_ff[ROW_W-1:0], walk_col_ff}
                                   : {ROW_W'(req_ff.read_row), COL_W'(req_ff.read_col)};

   always_ff @(posedge clock) begin
      if (wr_pend_ff) begin
         cell_mem[wr_addr_ff] <= wr_zero_ff ? 8'h00 : mem_q_ff;
      end else if (cmd.store_char) begin
         cell_mem[store_addr] <= req_ff.char_code;
      end
      if (cmd.read_cell || cmd.walk_en) mem_q_ff <= cell_mem[rd_addr];
   end

   // output register
   always_comb begin
      rsp_in.cell_char  = (status.is_read && in_area) ? mem_q_ff : 8'h00;
      rsp_in.cursor_row = 6'(cursor_row_ff);
      rsp_in.cursor_col = 8'(cursor_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/text_terminal_cell_buffer.sv
// Character-cell terminal store fed by a byte stream.
// req channel: operation 0 passes char_code to the terminal (printable
// bytes stored at the cursor, backspace, newline with scroll); operation 1
// reads the cell at read_row/read_col, 0 outside the area in use.
// rsp channel: one beat per request with the cell read and the cursor
// position after the request.
// csr channel: index 0 columns in use, index 1 rows in use; always ready.
// The user must write it only while no request is in flight; not enforced.
// Flow: a request runs accept, decode with the cell memory access, then
// response load, which raises rsp_valid; a scroll runs between decode
// and response load.
// A newline on the last row walks the cell memory one cell per cycle,
// over rows in use (saturated) * MAX_COLS cells. One request is in
// flight at a time.
// Reset: after reset the memory is cleared one cell per cycle,
// MAX_ROWS * MAX_COLS cells (8192 by default), with req_ready low.
// A response waits in the output register while rsp_ready is low; the next
// request is still accepted and holds in its last step until the register
// frees.
module text_terminal_cell_buffer #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttcb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttcb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);

   ttcb_pkg::cmd_type    cmd;
   ttcb_pkg::status_type status;

   assign csr_ready = 1'b1;

   ttcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttcb_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
